// ===== src/cordic_rotate_vector_q15_assert.svh =====
// Assertion macros for the CORDIC rotate/vectoring block.
// Expects a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef CORDIC_ROTATE_VECTOR_Q15_ASSERT_SVH
`define CORDIC_ROTATE_VECTOR_Q15_ASSERT_SVH
`ifndef ASSERT_OFF
`define CRV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CRV_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) trig |=> prop) else $error(msg);
`else
`define CRV_ASSERT(label, prop, msg)
`define CRV_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// ===== src/crv_pkg.sv =====
// Shared constants, word types and the arctangent step table of the CORDIC block.
// No dependencies; imported by every other file but the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package crv_pkg;

   localparam int ITERATIONS = 16;
   localparam int STEP_IDX_W = $clog2(ITERATIONS);
   localparam int DATA_W     = 16;
   localparam int WORK_W     = 32;
   // upper bits of the 32-bit binary angle; the step table never touches the low 14
   localparam int ACC_W      = 18;
   localparam int FRAC_W     = 15;

   localparam logic signed [DATA_W-1:0] GAIN_K       = 16'sh4DBA;
   localparam logic signed [DATA_W-1:0] Q15_MAX      = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] Q15_MIN      = -Q15_MAX;
   localparam logic signed [DATA_W-1:0] Q15_NEG_FULL = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [WORK_W:0]   ROUND_HALF   = (WORK_W+1)'(1 << (FRAC_W-1));
   localparam logic [ACC_W-1:0]         ACC_HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic CMD_ROTATE = 1'b0;
   localparam logic CMD_VECTOR = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [DATA_W-1:0]        angle;
   } item_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [WORK_W-1:0] x;
      logic signed [WORK_W-1:0] y;
      logic [DATA_W-1:0]        angle;
   } scaled_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [WORK_W-1:0] x;
      logic signed [WORK_W-1:0] y;
      logic [ACC_W-1:0]         acc;
   } work_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic [DATA_W-1:0]        angle;
   } result_type;

   // atan(2^-i), 0x20000 = 180 degrees
   function automatic logic [ACC_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
      logic [ACC_W-1:0] step;
      unique case (idx)
         0:       step = 18'h08000;
         1:       step = 18'h04B90;
         2:       step = 18'h027ED;
         3:       step = 18'h01444;
         4:       step = 18'h00A2C;
         5:       step = 18'h00517;
         6:       step = 18'h0028C;
         7:       step = 18'h00146;
         8:       step = 18'h000A3;
         9:       step = 18'h00051;
         10:      step = 18'h00029;
         11:      step = 18'h00014;
         12:      step = 18'h0000A;
         13:      step = 18'h00005;
         14:      step = 18'h00003;
         15:      step = 18'h00001;
         default: step = '0;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

// ===== src/crv_if.sv =====
// Valid/ready channel interfaces for request and response words of the CORDIC block.
// Depends on crv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface crv_req_if import crv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] x_in;
   logic signed [DATA_W-1:0] y_in;
   logic [DATA_W-1:0]        angle_in;

   modport source (output valid, cmd, x_in, y_in, angle_in, input ready);
   modport sink   (input valid, cmd, x_in, y_in, angle_in, output ready);
endinterface

interface crv_rsp_if import crv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] x_out;
   logic signed [DATA_W-1:0] y_out;
   logic [DATA_W-1:0]        angle_out;

   modport source (output valid, x_out, y_out, angle_out, input ready);
   modport sink   (input valid, x_out, y_out, angle_out, output ready);
endinterface

`default_nettype wire

// ===== src/cordic_rotate_vector_q15.sv =====
// Top level of the Q15 CORDIC rotator / vectoring unit.
// Depends on crv_pkg, crv_if, crv_prescale, crv_iter_pipe and crv_round.
//
// Fully pipelined CORDIC: while rsp_if.ready holds, one request word may enter on every
// clock and one response word leaves per clock. The registered stages are, in order, the
// 16x16 gain multiply, the quadrant fold, one per micro-rotation stage and rounding and
// saturation into the output register. cmd 0 rotates (x_in, y_in) by
// angle_in (65536 = full turn) and returns x_out, y_out with angle_out zero; cmd 1 returns
// the magnitude in x_out and the phase in angle_out with y_out zero. Every stage has its
// own valid bit and takes a new word whenever it is empty or its word moves on, so a
// stalled response only blocks requests once the whole pipeline is full; no word is
// dropped or repeated under back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module cordic_rotate_vector_q15 import crv_pkg::*; (
   input logic      clock,
   input logic      reset,
   crv_req_if.sink  req_if,
   crv_rsp_if.source rsp_if
);

   item_type   req_item;
   logic       pre_valid;
   logic       pre_ready;
   work_type   pre_work;
   logic       rot_valid;
   logic       rot_ready;
   work_type   rot_work;
   result_type rsp_result;

   assign req_item.cmd   = req_if.cmd;
   assign req_item.x     = req_if.x_in;
   assign req_item.y     = req_if.y_in;
   assign req_item.angle = req_if.angle_in;

   crv_prescale u_prescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_item   (req_item),
      .out_valid (pre_valid),
      .out_ready (pre_ready),
      .out_work  (pre_work)
   );

   crv_iter_pipe u_iter_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_ready  (pre_ready),
      .in_work   (pre_work),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_work  (rot_work)
   );

   crv_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rot_valid),
      .in_ready   (rot_ready),
      .in_work    (rot_work),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_result (rsp_result)
   );

   assign rsp_if.x_out     = rsp_result.x;
   assign rsp_if.y_out     = rsp_result.y;
   assign rsp_if.angle_out = rsp_result.angle;

endmodule

`default_nettype wire

// ===== src/crv_prescale.sv =====
// Gain pre-scale and quadrant fold: two pipeline stages ahead of the micro-rotations.
// Depends on crv_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "cordic_rotate_vector_q15_assert.svh"

module crv_prescale import crv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   logic       mul_valid_ff;
   scaled_type mul_ff;
   scaled_type mul_in;
   logic       mul_ready;

   logic       fold_valid_ff;
   work_type   fold_ff;
   work_type   fold_in;
   logic       fold_ready;
   logic       flip;

   assign fold_ready = !fold_valid_ff || out_ready;
   assign mul_ready  = !mul_valid_ff || fold_ready;
   assign in_ready   = mul_ready;

   always_comb begin
      mul_in.cmd   = in_item.cmd;
      mul_in.x     = in_item.x * GAIN_K;
      mul_in.y     = in_item.y * GAIN_K;
      mul_in.angle = in_item.angle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_ff <= mul_in;
      end
   end

   // rotate: quadrants 2 and 3 get half a turn added and the vector negated
   // vectoring: a negative x starts at half a turn with the vector negated
   always_comb begin
      fold_in.cmd = mul_ff.cmd;
      fold_in.x   = mul_ff.x;
      fold_in.y   = mul_ff.y;
      if (mul_ff.cmd == CMD_ROTATE) begin
         flip        = mul_ff.angle[DATA_W-1] ^ mul_ff.angle[DATA_W-2];
         fold_in.acc = {mul_ff.angle[DATA_W-1] ^ flip, mul_ff.angle[DATA_W-2:0],
                        {(ACC_W-DATA_W){1'b0}}};
      end else begin
         flip        = mul_ff.x[WORK_W-1];
         fold_in.acc = flip ? ACC_HALF_TURN : '0;
      end
      if (flip) begin
         fold_in.x = -mul_ff.x;
         fold_in.y = -mul_ff.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (fold_ready) begin
         fold_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fold_ready && mul_valid_ff) begin
         fold_ff <= fold_in;
      end
   end

   assign out_valid = fold_valid_ff;
   assign out_work  = fold_ff;

   `CRV_ASSERT(a_rot_folded, fold_valid_ff && fold_ff.cmd == CMD_ROTATE |-> fold_ff.acc[ACC_W-1] == fold_ff.acc[ACC_W-2], "rotate angle not folded into quadrants 1 and 4")
   `CRV_ASSERT(a_vec_folded, fold_valid_ff && fold_ff.cmd == CMD_VECTOR |-> !fold_ff.x[WORK_W-1], "vectoring x negative after fold")

endmodule

`default_nettype wire

// ===== src/crv_iter_pipe.sv =====
// Micro-rotation pipeline: one shift-add CORDIC step per register stage.
// Depends on crv_pkg for the step table and word types.
`timescale 1ns / 1ps
`default_nettype none
`include "cordic_rotate_vector_q15_assert.svh"

module crv_iter_pipe import crv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   logic     stg_valid_ff [ITERATIONS];
   work_type stg_ff       [ITERATIONS];
   logic     stg_ready    [ITERATIONS+1];

   assign stg_ready[ITERATIONS] = out_ready;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      work_type                 src;
      work_type                 stg_in;
      logic                     src_valid;
      logic                     cw;
      logic signed [WORK_W-1:0] x_sh;
      logic signed [WORK_W-1:0] y_sh;

      if (i == 0) begin : g_first
         assign src       = in_work;
         assign src_valid = in_valid;
      end else begin : g_rest
         assign src       = stg_ff[i-1];
         assign src_valid = stg_valid_ff[i-1];
      end

      // a stage takes a word when empty or when its own word moves on
      assign stg_ready[i] = !stg_valid_ff[i] || stg_ready[i+1];

      always_comb begin
         x_sh = src.x >>> i;
         y_sh = src.y >>> i;
         if (src.cmd == CMD_ROTATE) begin
            cw = src.acc[ACC_W-1];
         end else begin
            cw = !src.y[WORK_W-1] && (src.y != '0);
         end
         stg_in.cmd = src.cmd;
         if (cw) begin
            stg_in.x   = src.x + y_sh;
            stg_in.y   = src.y - x_sh;
            stg_in.acc = src.acc + atan_step(STEP_IDX_W'(i));
         end else begin
            stg_in.x   = src.x - y_sh;
            stg_in.y   = src.y + x_sh;
            stg_in.acc = src.acc - atan_step(STEP_IDX_W'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[i] <= 1'b0;
         end else if (stg_ready[i]) begin
            stg_valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_ready[i] && src_valid) begin
            stg_ff[i] <= stg_in;
         end
      end
   end

   assign in_ready  = stg_ready[0];
   assign out_valid = stg_valid_ff[ITERATIONS-1];
   assign out_work  = stg_ff[ITERATIONS-1];

   `CRV_ASSERT_NEXT(a_tail_hold, stg_valid_ff[ITERATIONS-1] && !out_ready, stg_valid_ff[ITERATIONS-1] && $stable(stg_ff[ITERATIONS-1]), "last rotation stage lost its word under stall")

endmodule

`default_nettype wire

// ===== src/crv_round.sv =====
// Output stage: round by 2^15, saturate to +/-32767, zero the unused field, hold the word.
// Depends on crv_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "cordic_rotate_vector_q15_assert.svh"

module crv_round import crv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  work_type   in_work,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [WORK_W-1:0] v
   );
      logic signed [WORK_W:0]        sum;
      logic signed [WORK_W-FRAC_W:0] r;
      logic signed [DATA_W-1:0]      res;
      sum = (WORK_W+1)'(v) + ROUND_HALF;
      r   = (WORK_W-FRAC_W+1)'(sum >>> FRAC_W);
      if (r > Q15_MAX) begin
         res = Q15_MAX;
      end else if (r < Q15_MIN) begin
         res = Q15_MIN;
      end else begin
         res = DATA_W'(r);
      end
      return res;
   endfunction

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      out_in.x = round_sat(in_work.x);
      if (in_work.cmd == CMD_ROTATE) begin
         out_in.y     = round_sat(in_work.y);
         out_in.angle = '0;
      end else begin
         out_in.y     = '0;
         out_in.angle = in_work.acc[ACC_W-1 -: DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         out_ff <= out_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   `CRV_ASSERT(a_x_sat, out_valid_ff |-> out_ff.x != Q15_NEG_FULL, "x_out outside saturation range")
   `CRV_ASSERT(a_y_sat, out_valid_ff |-> out_ff.y != Q15_NEG_FULL, "y_out outside saturation range")
   `CRV_ASSERT(a_one_mode, out_valid_ff && out_ff.y != '0 |-> out_ff.angle == '0, "word carries both a rotated y and a phase")

endmodule

`default_nettype wire

// ===== bench/tb_cordic_rotate_vector_q15.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Q15 CORDIC rotator / vectoring block.
// Depends on crv_pkg, crv_if and the cordic_rotate_vector_q15 RTL.

module tb_cordic_rotate_vector_q15 import crv_pkg::*; ;

   class cordic_scoreboard;
      result_type awaited_vectors[$];
      int         failures = 0;

      static function logic signed [DATA_W-1:0] q15_round_sat(input longint v);
         longint r;
         r = (v + 64'sd16384) >>> FRAC_W;
         if (r > 32767)
            r = 32767;
         if (r < -32767)
            r = -32767;
         return r[DATA_W-1:0];
      endfunction

      // One full CORDIC pass, worked in 64-bit arithmetic with a 32-bit binary angle
      static function result_type cordic_compute(input item_type w);
         logic [15:0] arctan [16];
         longint      x;
         longint      y;
         longint      nx;
         logic [31:0] acc;
         logic [31:0] step;
         logic [15:0] ang;
         logic        cw;
         result_type  r;
         arctan = '{16'h8000, 16'h4B90, 16'h27ED, 16'h1444, 16'h0A2C, 16'h0517, 16'h028C,
                    16'h0146, 16'h00A3, 16'h0051, 16'h0029, 16'h0014, 16'h000A, 16'h0005,
                    16'h0003, 16'h0001};
         x = longint'(w.x) * longint'(GAIN_K);
         y = longint'(w.y) * longint'(GAIN_K);
         if (w.cmd == CMD_ROTATE) begin
            ang = w.angle;
            // fold quadrants 2 and 3 onto the right half-plane
            if (ang >= 16'h4000 && ang <= 16'hBFFF) begin
               ang = ang + 16'h8000;
               x = -x;
               y = -y;
            end
            acc = {ang, 16'h0000};
         end else begin
            acc = 32'h0;
            if (x < 0) begin
               acc = 32'h8000_0000;
               x = -x;
               y = -y;
            end
         end
         for (int i = 0; i < ITERATIONS; i++) begin
            step = 32'(arctan[i]) << 14;
            cw = (w.cmd == CMD_ROTATE) ? acc[31] : (y > 0);
            if (cw) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               acc = acc + step;
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               acc = acc - step;
            end
            x = nx;
         end
         r.x = q15_round_sat(x);
         if (w.cmd == CMD_ROTATE) begin
            r.y = q15_round_sat(y);
            r.angle = '0;
         end else begin
            r.y = '0;
            r.angle = acc[31:16];
         end
         return r;
      endfunction

      function void note_request(input item_type w);
         awaited_vectors.push_back(cordic_compute(w));
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (awaited_vectors.size() == 0) begin
            $error("response word with nothing outstanding: x_out %0d y_out %0d angle_out %h",
                   got.x, got.y, got.angle);
            failures++;
            return;
         end
         want = awaited_vectors.pop_front();
         if (got.x !== want.x) begin
            $error("x_out: expected %0d, got %0d", want.x, got.x);
            failures++;
         end
         if (got.y !== want.y) begin
            $error("y_out: expected %0d, got %0d", want.y, got.y);
            failures++;
         end
         if (got.angle !== want.angle) begin
            $error("angle_out: expected %h, got %h", want.angle, got.angle);
            failures++;
         end
      endfunction

      function int outstanding();
         return awaited_vectors.size();
      endfunction
   endclass

   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 2 * (ITERATIONS + 3);

   logic clock;
   logic reset;

   crv_req_if req();
   crv_rsp_if rsp();

   cordic_rotate_vector_q15 dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   cordic_scoreboard board = new();

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int holds_asked = 0;
   int holds_granted = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // response side: random stalls, plus a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (holds_granted != holds_asked) begin
         holds_granted = holds_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_request('{req.cmd, req.x_in, req.y_in, req.angle_in});
         if (rsp.valid && rsp.ready)
            board.check_result('{rsp.x_out, rsp.y_out, rsp.angle_out});
      end
   end

   task automatic send_word(input item_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= w.cmd;
      req.x_in <= w.x;
      req.y_in <= w.y;
      req.angle_in <= w.angle;
      do @(posedge clock); while (req.ready !== 1'b1);
   endtask

   task automatic send_fields(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] angle);
      send_word('{cmd, x, y, angle});
   endtask

   function automatic logic [15:0] random_component();
      logic [15:0] extremes [5];
      extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      unique case ($urandom_range(7))
         0:       return extremes[$urandom_range(4)];
         1:       return 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic item_type random_word();
      item_type w;
      w.cmd = 1'($urandom_range(1));
      w.x = random_component();
      w.y = random_component();
      // a quarter of the angles sit next to a quadrant boundary
      if ($urandom_range(3) == 0)
         w.angle = 16'($urandom_range(3)) * 16'h4000 + 16'($urandom_range(8)) - 16'd4;
      else
         w.angle = 16'($urandom);
      return w;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_word(random_word());
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = CMD_ROTATE;
      req.x_in = '0;
      req.y_in = '0;
      req.angle_in = '0;
      rsp.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rotation: fold boundaries and full-scale inputs
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h0000, 16'h0000);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h0000, 16'h3FFF);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h0000, 16'h4000);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h0000, 16'hBFFF);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h0000, 16'hC000);
      send_fields(CMD_ROTATE, 16'h8000, 16'h8000, 16'h2000);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_fields(CMD_ROTATE, 16'h8000, 16'h7FFF, 16'h8000);
      send_fields(CMD_ROTATE, 16'h0000, 16'h0000, 16'h1234);
      send_fields(CMD_ROTATE, 16'h7FFF, 16'h8000, 16'h6000);
      send_fields(CMD_ROTATE, 16'hFFFF, 16'h0001, 16'h0001);
      // vectoring: zero vector, negative x, axes and corners; angle ignored
      send_fields(CMD_VECTOR, 16'h0000, 16'h0000, 16'hFFFF);
      send_fields(CMD_VECTOR, 16'h7FFF, 16'h0000, 16'h0000);
      send_fields(CMD_VECTOR, 16'h8000, 16'h0000, 16'hFFFF);
      send_fields(CMD_VECTOR, 16'h8000, 16'h8000, 16'h5555);
      send_fields(CMD_VECTOR, 16'h7FFF, 16'h7FFF, 16'hAAAA);
      send_fields(CMD_VECTOR, 16'h0000, 16'h7FFF, 16'h0000);
      send_fields(CMD_VECTOR, 16'h0000, 16'h8000, 16'h0000);
      send_fields(CMD_VECTOR, 16'hFFFF, 16'h0000, 16'h0000);
      send_fields(CMD_VECTOR, 16'h0001, 16'hFFFF, 16'h0000);
      send_fields(CMD_VECTOR, 16'h8000, 16'h7FFF, 16'h0000);
      send_fields(CMD_VECTOR, 16'h3039, 16'hA460, 16'h0000);

      send_random(380);
      sender_idle_pct = 67;
      send_random(380);
      sender_idle_pct = 0;
      receiver_stall_pct <= 67;
      send_random(380);
      sender_idle_pct = 32;
      receiver_stall_pct <= 32;
      send_random(380);

      // hold the response side off while words keep coming, so the pipeline backs up
      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      holds_asked <= holds_asked + 1;
      send_random(150);
      holds_asked <= holds_asked + 1;
      send_random(150);
      req.valid <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
